FILE: sv/release_sort_earliest_door_scheduler_core_macros.svh
// Assertion helpers shared by the scheduler RTL.
`ifndef RELEASE_SORT_EARLIEST_DOOR_SCHEDULER_CORE_MACROS_SVH
`define RELEASE_SORT_EARLIEST_DOOR_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define RSED_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define RSED_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/rsed_pkg.sv
package rsed_pkg;

    localparam int MAX_JOBS   = 64;
    localparam int JOB_BITS   = $clog2(MAX_JOBS);
    localparam int CNT_BITS   = $clog2(MAX_JOBS + 1);
    localparam int MAX_DOORS  = 16;
    localparam int DOOR_BITS  = $clog2(MAX_DOORS);
    localparam int DCNT_BITS  = 5;
    localparam int TIME_BITS  = 16;
    localparam int START_BITS = 23;

    localparam logic [START_BITS-1:0] START_MAX = {START_BITS{1'b1}};

    // register index
    localparam int REG_DOOR_COUNT = 0;

    // sequencer states
    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_ASSIGN = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [TIME_BITS-1:0] ready;
        logic [TIME_BITS-1:0] dur;
        logic [JOB_BITS-1:0]  idx;
    } job_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctl_t;

endpackage

FILE: sv/rsed_cell.sv
// One slot of the sorted job chain. Empty slots sort as +infinity.
module rsed_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  rsed_pkg::cell_ctl_t ctl,
    input  rsed_pkg::job_t    new_job,
    input  rsed_pkg::job_t    prev_job,
    input  logic              prev_lt,
    input  rsed_pkg::job_t    next_job,
    output rsed_pkg::job_t    job,
    output logic              lt
);

    rsed_pkg::job_t job_reg;
    rsed_pkg::job_t job_next;

    // strict compare: equal keys keep load order
    assign lt = !job_reg.valid ||
                ({new_job.ready, new_job.dur} < {job_reg.ready, job_reg.dur});
    assign job = job_reg;

    always_comb begin
        job_next = job_reg;
        if (ctl.pop) begin
            job_next = next_job;
        end else if (ctl.insert && lt) begin
            if (prev_lt) begin
                job_next = prev_job;
            end else begin
                job_next = new_job;
                job_next.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg.valid <= 1'b0;
        end else begin
            job_reg.valid <= job_next.valid;
        end
        job_reg.ready <= job_next.ready;
        job_reg.dur   <= job_next.dur;
        job_reg.idx   <= job_next.idx;
    end

endmodule

FILE: sv/release_sort_earliest_door_scheduler_core.sv
// Load: one job beat per cycle; the first 64 are inserted in sorted place by the cell chain.
// Schedule: after the last beat, each job is scanned (D = doors in use: D-1 door
// compares, one a cycle, then an exit check) and then assigned, with a stall while
// the output register is held. Synchronous active-low reset empties the chain,
// clears job count, sets door_count to 1; door times clear at each schedule.
module release_sort_earliest_door_scheduler_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] ready_time, [31:16] duration
    input  logic        s_tlast,   // last_job
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [5:0] job_index, [9:6] door, [32:10] start_time
    output logic        m_tlast,   // last_result
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NJ = rsed_pkg::MAX_JOBS;
    localparam int ND = rsed_pkg::MAX_DOORS;
    localparam int SB = rsed_pkg::START_BITS;

    // ---------------- config register ----------------
    logic [rsed_pkg::DCNT_BITS-1:0] door_count_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[2] == 1'(rsed_pkg::REG_DOOR_COUNT));
    assign prdata = (paddr[2] == 1'(rsed_pkg::REG_DOOR_COUNT)) ?
                    {{(32-rsed_pkg::DCNT_BITS){1'b0}}, door_count_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            door_count_reg <= rsed_pkg::DCNT_BITS'(1);
        end else if (cfg_wr) begin
            door_count_reg <= pwdata[rsed_pkg::DCNT_BITS-1:0];
        end
    end

    // zero means one door, above the door array saturates
    logic [rsed_pkg::DCNT_BITS-1:0] doors_eff;
    always_comb begin
        if (door_count_reg == '0)
            doors_eff = rsed_pkg::DCNT_BITS'(1);
        else if (door_count_reg > rsed_pkg::DCNT_BITS'(ND))
            doors_eff = rsed_pkg::DCNT_BITS'(ND);
        else
            doors_eff = door_count_reg;
    end

    // ---------------- control ----------------
    logic [1:0] state_reg, state_next;
    logic [rsed_pkg::CNT_BITS-1:0] count_reg, count_next;
    logic [rsed_pkg::DCNT_BITS-1:0] scan_reg, scan_next;
    logic [rsed_pkg::DOOR_BITS-1:0] best_reg, best_next;
    logic [SB-1:0] door_free_reg [ND];
    logic out_valid_reg;
    logic [39:0] out_data_reg;
    logic out_last_reg;

    logic in_acc, out_free, do_assign;
    rsed_pkg::cell_ctl_t ctl;
    rsed_pkg::job_t new_job;
    rsed_pkg::job_t cell_q [NJ];
    logic cell_lt [NJ];

    assign s_tready  = (state_reg == rsed_pkg::ST_LOAD);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign do_assign = (state_reg == rsed_pkg::ST_ASSIGN) && out_free;

    assign ctl.insert = in_acc && (count_reg < rsed_pkg::CNT_BITS'(NJ));
    assign ctl.pop    = do_assign;

    always_comb begin
        new_job.valid = 1'b1;
        new_job.ready = s_tdata[15:0];
        new_job.dur   = s_tdata[31:16];
        new_job.idx   = count_reg[rsed_pkg::JOB_BITS-1:0];
    end

    // ---------------- sorted chain ----------------
    for (genvar i = 0; i < NJ; i++) begin : g_cell
        rsed_pkg::job_t pj, nj;
        logic plt;
        if (i == 0) begin : g_first
            assign pj  = '0;
            assign plt = 1'b0;
        end else begin : g_mid
            assign pj  = cell_q[i-1];
            assign plt = cell_lt[i-1];
        end
        if (i == NJ-1) begin : g_last
            assign nj = '0;
        end else begin : g_inner
            assign nj = cell_q[i+1];
        end
        rsed_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .new_job  (new_job),
            .prev_job (pj),
            .prev_lt  (plt),
            .next_job (nj),
            .job      (cell_q[i]),
            .lt       (cell_lt[i])
        );
    end

    // ---------------- door pick and start time ----------------
    logic [SB-1:0] best_free, scan_free, start_t, ready_ext;
    logic [SB:0]   finish_w;
    logic [SB-1:0] finish_t;

    assign best_free = door_free_reg[best_reg];
    assign scan_free = door_free_reg[scan_reg[rsed_pkg::DOOR_BITS-1:0]];
    assign ready_ext = SB'(cell_q[0].ready);
    assign start_t   = (ready_ext > best_free) ? ready_ext : best_free;
    assign finish_w  = {1'b0, start_t} + (SB+1)'(cell_q[0].dur);
    assign finish_t  = finish_w[SB] ? rsed_pkg::START_MAX : finish_w[SB-1:0];

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        best_next  = best_reg;
        unique case (state_reg)
            rsed_pkg::ST_LOAD: begin
                if (ctl.insert)
                    count_next = count_reg + 1'b1;
                if (in_acc && s_tlast) begin
                    state_next = rsed_pkg::ST_SCAN;
                    scan_next  = rsed_pkg::DCNT_BITS'(1);
                    best_next  = '0;
                end
            end
            rsed_pkg::ST_SCAN: begin
                if (scan_reg >= doors_eff) begin
                    state_next = rsed_pkg::ST_ASSIGN;
                end else begin
                    if (scan_free < best_free)
                        best_next = scan_reg[rsed_pkg::DOOR_BITS-1:0];
                    scan_next = scan_reg + 1'b1;
                end
            end
            rsed_pkg::ST_ASSIGN: begin
                if (out_free) begin
                    count_next = count_reg - 1'b1;
                    scan_next  = rsed_pkg::DCNT_BITS'(1);
                    best_next  = '0;
                    state_next = (count_reg == rsed_pkg::CNT_BITS'(1)) ?
                                 rsed_pkg::ST_LOAD : rsed_pkg::ST_SCAN;
                end
            end
            default: state_next = rsed_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rsed_pkg::ST_LOAD;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (do_assign)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        best_reg <= best_next;
        if (do_assign) begin
            out_data_reg <= {7'd0, start_t, best_reg, cell_q[0].idx};
            out_last_reg <= (count_reg == rsed_pkg::CNT_BITS'(1));
        end
    end

    // door free times: cleared at schedule start, updated on assign
    for (genvar d = 0; d < ND; d++) begin : g_door
        always_ff @(posedge aclk) begin
            if (in_acc && s_tlast)
                door_free_reg[d] <= '0;
            else if (do_assign && best_reg == rsed_pkg::DOOR_BITS'(d))
                door_free_reg[d] <= finish_t;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // ---------------- checks ----------------
`include "release_sort_earliest_door_scheduler_core_macros.svh"

    `RSED_ASSERT_NOW(a_head_valid, aclk, aresetn, state_reg == rsed_pkg::ST_ASSIGN, cell_q[0].valid)
    `RSED_ASSERT_NOW(a_count_cap, aclk, aresetn, 1'b1, count_reg <= rsed_pkg::CNT_BITS'(NJ))
    `RSED_ASSERT_NEXT(a_last_done, aclk, aresetn, do_assign && count_reg == rsed_pkg::CNT_BITS'(1), count_reg == '0 && state_reg == rsed_pkg::ST_LOAD)
    `RSED_ASSERT_NEXT(a_start_sched, aclk, aresetn, in_acc && s_tlast, state_reg == rsed_pkg::ST_SCAN && count_reg != '0)

endmodule
